@@ rtl/float_to_decimal_ascii_defines.svh @@
// assertion macros for the float to decimal text block
// included by the top level, no other dependencies
`ifndef FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH
`define FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define F2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define F2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/f2d_pkg.sv @@
// shared types and constants for the float to decimal text block
// no dependencies
package f2d_pkg;

    localparam int OUT_BUFFER_LEN_DEF = 32;
    localparam int FRAC_DIGITS_MAX    = 5;
    localparam int EXP_BIAS           = 127;
    localparam int MANT_BITS          = 23;
    localparam logic [31:0] SMALL_BOUND = 32'h3727C5AC; // 1e-5 in single precision
    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_DOT  = 7'h2E;
    localparam logic [6:0] CH_NUL  = 7'h00;

    // payload of one input item
    typedef struct packed {
        logic [31:0] float_bits;
    } t_in_item;

    // payload of one result item
    typedef struct packed {
        logic [6:0] out_char;
        logic       is_last;
        logic       range_error;
    } t_out_item;

    // item class decided by the front part
    typedef enum logic [1:0] {
        K_SMALL,
        K_RANGE,
        K_NUM
    } t_kind;

    // queue entry between front and back
    typedef struct packed {
        t_kind       kind;
        logic [30:0] int_val;
        logic [23:0] frac;
    } t_job;

    // back part sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FRAC,
        S_EMIT
    } t_state;

endpackage

@@ rtl/f2d_if.sv @@
// valid/ready channel interface with a generic payload
// depends on nothing
interface f2d_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/f2d_front.sv @@
// front part: single-precision add of 1e-5, unpack, classify; two stages
// depends on f2d_pkg
module f2d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_bits,
    output logic            o_valid,
    input  logic            i_ready,
    output f2d_pkg::t_job   o_job
);
    import f2d_pkg::*;

    // stage one: aligned operands
    logic        r_v1, n_v1;
    logic        r_small;
    logic [7:0]  r_exp;
    logic [49:0] r_sum;      // sum of mantissas aligned, 25 guard bits
    logic        r_sticky;
    // stage two output
    logic        r_v2;
    t_job        r_job;

    logic        adv2, adv1;
    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_job   = r_job;

    // compare and align: value >= bound or a nan here, so exponent a >= bound's
    // a nan of either sign is never small
    logic        small_c;
    logic        nan_c;
    logic [7:0]  ea, eb, d;
    logic [23:0] ma, mb;
    logic [49:0] shb;
    logic        st;
    logic [75:0] wide;
    always_comb begin
        nan_c   = (i_bits[30:23] == 8'hFF) && (i_bits[22:0] != 23'd0);
        small_c = !nan_c && (i_bits[31] || (i_bits[30:0] < SMALL_BOUND[30:0]));
        ea = i_bits[30:23];
        eb = SMALL_BOUND[30:23];
        ma = {(ea != 8'd0), i_bits[22:0]};
        mb = {1'b1, SMALL_BOUND[22:0]};
        d  = ea - eb;
        wide = {1'b0, mb, 51'd0} >> ((d > 8'd60) ? 8'd60 : d);
        shb = wide[75:26];
        st  = |wide[25:0];
        n_v1 = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= n_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_small  <= small_c;
            r_exp    <= ea;
            r_sum    <= {1'b0, ma, 25'd0} + shb;
            r_sticky <= st;
        end
    end

    // stage two: normalise, round to nearest even, split
    logic [23:0] m;
    logic [8:0]  e;
    logic        g, rs, up;
    logic [24:0] mr;
    logic signed [9:0] ex;
    logic [54:0] fix;   // 31 integer bits, 24 fraction bits
    t_job        nj;
    always_comb begin
        if (r_sum[49]) begin
            m  = r_sum[49:26];
            g  = r_sum[25];
            rs = (|r_sum[24:0]) || r_sticky;
            e  = {1'b0, r_exp} + 9'd1;
        end else begin
            m  = r_sum[48:25];
            g  = r_sum[24];
            rs = (|r_sum[23:0]) || r_sticky;
            e  = {1'b0, r_exp};
        end
        up = g && (rs || m[0]);
        mr = {1'b0, m} + {24'd0, up};
        if (mr[24]) begin
            m = mr[24:1];
            e = e + 9'd1;
        end else begin
            m = mr[23:0];
        end
        ex  = $signed({1'b0, e}) - 10'sd127;
        fix = '0;
        nj  = '0;
        if (r_small) begin
            nj.kind = K_SMALL;
        end else if (ex >= 10'sd31) begin
            nj.kind = K_RANGE;
        end else begin
            nj.kind = K_NUM;
            // value = m * 2^(ex-23); fixed point has 24 fraction bits
            if (ex >= 10'sd0) begin
                fix = {31'd0, m} << (ex[4:0] + 5'd1);
            end else if (ex >= -10'sd23) begin
                fix = {31'd0, m} >> (5'(-(ex + 10'sd1)));
            end
            nj.int_val = fix[54:24];
            nj.frac    = fix[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_job <= nj;
        end
    end
endmodule

@@ rtl/f2d_queue.sv @@
// two-entry item queue between front and back parts
// depends on f2d_pkg
module f2d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  f2d_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output f2d_pkg::t_job o_job
);
    import f2d_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
    end
endmodule

@@ rtl/f2d_back.sv @@
// back part: digit conversion and character emission
// depends on f2d_pkg
module f2d_back #(
    parameter int OUT_BUFFER_LEN = f2d_pkg::OUT_BUFFER_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  f2d_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [6:0]    o_char,
    output logic          o_last,
    output logic          o_err
);
    import f2d_pkg::*;

    localparam int NCH = 18;
    localparam int CW  = $clog2(NCH + 1);

    t_state      r_st, n_st;
    t_kind       r_kind;
    logic [30:0] r_int;     // remaining integer value
    logic [23:0] r_frac;
    logic [3:0]  r_ch [FRAC_DIGITS_MAX];
    logic [3:0]  r_nint;    // integer digits produced
    logic [2:0]  r_nfd;     // fraction digits produced
    logic [2:0]  r_lastnz;  // count up to last non-zero fraction digit
    logic [CW-1:0] r_len, r_pos;
    logic [3:0]  r_idigs [10];

    // divide by ten by reciprocal multiply
    logic [30:0] q;
    logic [63:0] pr;
    logic [3:0]  rem;
    always_comb begin
        pr  = {33'd0, r_int} * 64'hCCCCCCCD;
        q   = 31'(pr[63:35]);
        rem = 4'(r_int - 31'(q * 31'd10));
    end
    logic [27:0] f10;
    assign f10 = {4'd0, r_frac} * 28'd10;

    // fraction digits stop at five, at a zero remainder or at the text length bound
    logic        frac_done;
    assign frac_done = (r_nfd == 3'(FRAC_DIGITS_MAX)) || (r_frac == 24'd0)
        || (int'(r_nint) + int'(r_nfd) + 2 >= OUT_BUFFER_LEN);

    logic        take, fire, is_last;
    assign take    = (r_st == S_IDLE) && i_valid;
    assign o_ready = (r_st == S_IDLE);
    assign fire    = o_valid && i_ready;
    assign is_last = (r_pos == r_len - CW'(1));

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) begin
                if (i_job.kind == K_NUM) n_st = S_CONV;
                else n_st = S_EMIT;
            end
            S_CONV: if (r_int == 31'd0) n_st = S_FRAC;
            S_FRAC: if (frac_done) n_st = S_EMIT;
            S_EMIT: if (fire && is_last) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // outputs
    logic [3:0] ci;
    always_comb begin
        o_valid = (r_st == S_EMIT);
        o_err   = (r_kind == K_RANGE);
        o_last  = is_last;
        ci      = 4'd0;
        o_char  = CH_ZERO;
        if (r_kind == K_RANGE) begin
            o_char = CH_NUL;
        end else if (r_kind == K_SMALL) begin
            o_char = (r_pos == CW'(1)) ? CH_DOT : CH_ZERO;
        end else begin
            if (r_pos < CW'(r_nint)) begin
                ci = r_idigs[4'(CW'(r_nint) - CW'(1) - r_pos)];
                o_char = CH_ZERO + {3'd0, ci};
            end else if (r_pos == CW'(r_nint)) begin
                o_char = CH_DOT;
            end else begin
                o_char = CH_ZERO + {3'd0, r_ch[3'(r_pos - CW'(r_nint) - CW'(1))]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (take) begin
                r_kind   <= i_job.kind;
                r_int    <= i_job.int_val;
                r_frac   <= i_job.frac;
                r_nint   <= 4'd0;
                r_nfd    <= 3'd0;
                r_lastnz <= 3'd0;
                r_pos    <= '0;
                r_len    <= (i_job.kind == K_RANGE) ? CW'(1) : CW'(3);
            end
            S_CONV: begin
                if (r_int != 31'd0) begin
                    r_idigs[r_nint] <= rem;
                    r_nint <= r_nint + 4'd1;
                    r_int  <= q;
                end else if (r_nint == 4'd0) begin
                    r_idigs[0] <= 4'd0;
                    r_nint <= 4'd1;
                end
            end
            S_FRAC: begin
                if (!frac_done) begin
                    r_ch[r_nfd] <= f10[27:24];
                    r_nfd  <= r_nfd + 3'd1;
                    r_frac <= f10[23:0];
                    if (f10[27:24] != 4'd0) r_lastnz <= r_nfd + 3'd1;
                end else begin
                    // one fraction digit stays at least
                    if (r_lastnz == 3'd0) r_ch[0] <= 4'd0;
                    r_len <= CW'(r_nint) + CW'(1)
                        + ((r_lastnz == 3'd0) ? CW'(1) : CW'(r_lastnz));
                end
            end
            S_EMIT: if (fire) r_pos <= r_pos + CW'(1);
            default: ;
        endcase
    end
endmodule

@@ rtl/float_to_decimal_ascii.sv @@
// top level of the float to decimal text converter
// depends on f2d_pkg, f2d_if, f2d_front, f2d_queue, f2d_back, defines header
//
//  channel | dir | payload
//  in      | in  | float_bits[31:0]
//  out     | out | out_char[6:0], is_last, range_error
//
// front: two pipelined stages, then a two-entry queue
// back: one item at a time; for a number, integer digits one a cycle, then fraction digits
// one a cycle; small and error items skip both; then one character a cycle while the output
// is ready; a stalled output holds the back part, and a full queue then stalls the front
// reset clears all handshake and sequencer state
`include "float_to_decimal_ascii_defines.svh"
module float_to_decimal_ascii #(
    parameter int OUT_BUFFER_LEN = f2d_pkg::OUT_BUFFER_LEN_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    f2d_if.sink   i_in,
    f2d_if.source o_out
);
    import f2d_pkg::*;

    logic q_v, q_r, b_v, b_r;
    t_job q_j, b_j;
    logic [6:0] ch;
    logic lst, er;

    f2d_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_bits(i_in.data.float_bits),
        .o_valid(q_v), .i_ready(q_r), .o_job(q_j)
    );
    f2d_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_job(q_j),
        .o_valid(b_v), .i_ready(b_r), .o_job(b_j)
    );
    f2d_back #(.OUT_BUFFER_LEN(OUT_BUFFER_LEN)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_v), .o_ready(b_r), .i_job(b_j),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_char(ch), .o_last(lst), .o_err(er)
    );
    assign o_out.data.out_char    = ch;
    assign o_out.data.is_last     = lst;
    assign o_out.data.range_error = er;

    // checks
    `F2D_ASSERT(a_err_last, !(o_out.valid && er) || lst, "error item not last")
    `F2D_ASSERT(a_err_nul, !(o_out.valid && er) || ch == CH_NUL, "error item not nul")
    `F2D_ASSERT_NEXT(a_hold, o_out.valid && !o_out.ready, o_out.valid, "output dropped")
endmodule
